// File: rtl/ipdf_pkg.sv
`timescale 1ns / 1ps
package ipdf_pkg;

    // Grid resolution per channel.
    localparam int RED_BITS   = 6;
    localparam int GREEN_BITS = 6;
    localparam int BLUE_BITS  = 6;
    localparam int MAX_BITS   = 8;
    localparam int CELL_W     = RED_BITS + GREEN_BITS + BLUE_BITS;

    // Squared distances per axis and their sum.
    localparam int SQ_W       = 2 * MAX_BITS;
    localparam int DIST_W     = SQ_W + 2;
    localparam int STORE_W    = 14;
    localparam logic [STORE_W-1:0] UNREACHED = '1;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd;

    typedef struct packed {
        logic [7:0] palette_index;
        logic       claimed_any;
    } t_res;

    // One grid cell as held in the store.
    typedef struct packed {
        logic [STORE_W-1:0] sq_dist;
        logic [7:0]         idx;
    } t_cell;

endpackage

// File: rtl/ipdf_ram.sv
`timescale 1ns / 1ps
module ipdf_ram
    import ipdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [CELL_W-1:0] i_addr,
    input  t_cell             i_wdata,
    output t_cell             o_rdata
);

    t_cell r_mem [2**CELL_W];

    // Single port store with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: rtl/inverse_palette_distance_fill.sv
`timescale 1ns / 1ps
// Inverse palette builder over a 64x64x64 grid held in one single port store.
// A transaction is taken when start is high and busy is low; its result
// appears on o_result for exactly one cycle with o_done high and cannot be
// stalled. After reset the block sweeps the store (busy high) before it
// takes the first transaction. A clear also sweeps the whole store, a lookup
// reads the colour's cell and returns its index, and an unused opcode raises
// o_done without touching the store. An insert walks outward from the
// colour's cell, reading each cell it visits and then comparing and writing
// on a win, with bookkeeping states per row and plane, so its length depends
// on the palette built so far.
module inverse_palette_distance_fill
    import ipdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_res o_result
);

    localparam int RW = RED_BITS;
    localparam int GW = GREEN_BITS;
    localparam int BW = BLUE_BITS;
    localparam logic [RW:0] RED_CELLS   = (RW+1)'(1 << RW);
    localparam logic [GW:0] GREEN_CELLS = (GW+1)'(1 << GW);
    localparam logic [BW:0] BLUE_CELLS  = (BW+1)'(1 << BW);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_RROW, S_GROW, S_RD, S_CMP, S_BDIR,
        S_GROWEND, S_GDIR, S_RROWEND, S_LK_RD, S_LK_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_idx, n_idx;
    logic [RW-1:0]     r_cr, n_cr, r_rk, n_rk;
    logic [GW-1:0]     r_cg, n_cg, r_gk, n_gk;
    logic [BW-1:0]     r_cb, n_cb, r_bk, n_bk;
    logic [SQ_W-1:0]   r_dr, n_dr, r_dg, n_dg, r_db, n_db;
    logic              r_rdir, n_rdir, r_gdir, n_gdir, r_bdir, n_bdir;
    logic              r_rany, n_rany, r_gany, n_gany, r_bany, n_bany;
    logic              r_total, n_total, r_growany, n_growany, r_browany, n_browany;
    logic [3:0]        r_skip, n_skip;
    logic [CELL_W-1:0] r_clr, n_clr;
    logic              r_clr_out, n_clr_out;
    logic              n_done;
    t_res              n_result;

    logic [RW-1:0]     rc;
    logic [GW-1:0]     gc;
    logic [BW-1:0]     bc;
    logic [CELL_W-1:0] mem_addr;
    logic              mem_we;
    t_cell             mem_wdata, mem_q;
    logic [DIST_W-1:0] cur_dist;
    logic              improve, cont, stop, brun;

    // Current cell and its squared distance from the centre.
    always_comb begin
        rc   = r_rdir ? (r_cr - r_rk) : (r_cr + r_rk);
        gc   = r_gdir ? (r_cg - r_gk) : (r_cg + r_gk);
        bc   = r_bdir ? (r_cb - r_bk) : (r_cb + r_bk);
        cur_dist = DIST_W'(r_dr) + DIST_W'(r_dg) + DIST_W'(r_db);
        improve = cur_dist < DIST_W'(mem_q.sq_dist);
        brun = r_browany | r_bany;
    end

    assign busy = (r_state != S_IDLE);

    // Store port: sweep address while clearing, walk cell otherwise.
    always_comb begin
        mem_addr  = (r_state == S_CLR) ? r_clr : {rc, gc, bc};
        mem_we    = (r_state == S_CLR) || ((r_state == S_CMP) && improve);
        mem_wdata = (r_state == S_CLR) ? t_cell'{sq_dist: UNREACHED, idx: 8'd0}
                                       : t_cell'{sq_dist: STORE_W'(cur_dist), idx: r_idx};
    end

    ipdf_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_q)
    );

    // Sequencer: clear sweep, lookup, and insert walk over red rows, green rows, blue cells.
    always_comb begin
        n_state = r_state;   n_idx = r_idx;
        n_cr = r_cr;   n_cg = r_cg;   n_cb = r_cb;
        n_rk = r_rk;   n_gk = r_gk;   n_bk = r_bk;
        n_dr = r_dr;   n_dg = r_dg;   n_db = r_db;
        n_rdir = r_rdir;   n_gdir = r_gdir;   n_bdir = r_bdir;
        n_rany = r_rany;   n_gany = r_gany;   n_bany = r_bany;
        n_total = r_total;   n_growany = r_growany;   n_browany = r_browany;
        n_skip = r_skip;   n_clr = r_clr;   n_clr_out = r_clr_out;
        n_done = 1'b0;
        n_result = '0;
        cont = 1'b0;
        stop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx = i_cmd.color_index;
                    n_cr = i_cmd.red[7 -: RW];
                    n_cg = i_cmd.green[7 -: GW];
                    n_cb = i_cmd.blue[7 -: BW];
                    n_rk = '0;   n_gk = '0;   n_bk = '0;
                    n_dr = '0;   n_dg = '0;   n_db = '0;
                    n_rdir = 1'b0;   n_gdir = 1'b0;   n_bdir = 1'b0;
                    n_rany = 1'b0;   n_total = 1'b0;
                    case (i_cmd.opcode)
                        OP_CLEAR: begin
                            n_clr = '0;
                            n_clr_out = 1'b1;
                            n_state = S_CLR;
                        end
                        OP_INSERT: begin
                            n_skip[3:2] = 2'b00;
                            n_state = S_RROW;
                        end
                        OP_LOOKUP: begin
                            n_state = S_LK_RD;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_done = r_clr_out;
                    n_state = S_IDLE;
                end
            end
            S_LK_RD: begin
                n_state = S_LK_WAIT;
            end
            S_LK_WAIT: begin
                n_done = 1'b1;
                n_result.palette_index = mem_q.idx;
                n_state = S_IDLE;
            end
            // Start of one green sweep within a red row.
            S_RROW: begin
                n_skip[1:0] = 2'b00;
                n_gdir = 1'b0;   n_gk = '0;   n_dg = '0;
                n_gany = 1'b0;   n_growany = 1'b0;
                n_state = r_skip[2] ? S_GDIR : S_GROW;
            end
            // Start of one blue run within a green row.
            S_GROW: begin
                n_bdir = 1'b0;   n_bk = '0;   n_db = '0;
                n_bany = 1'b0;   n_browany = 1'b0;
                n_state = r_skip[0] ? S_BDIR : S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            // Compare against the stored distance; the store writes on a win.
            S_CMP: begin
                if (improve) begin
                    n_bany = 1'b1;
                end
                stop = !improve && r_bany;
                if (r_bdir) begin
                    cont = ((BW+1)'(r_bk) + 1'b1) <= (BW+1)'(r_cb);
                end else begin
                    cont = ((BW+1)'(r_cb) + (BW+1)'(r_bk) + 1'b1) < BLUE_CELLS;
                end
                n_bk = r_bk + 1'b1;
                n_db = r_db + SQ_W'({r_bk, 1'b1});
                n_state = (stop || !cont) ? S_BDIR : S_RD;
            end
            S_BDIR: begin
                if (!r_bany) begin
                    n_skip[r_bdir] = 1'b1;
                end
                n_browany = brun;
                if (!r_bdir) begin
                    n_bdir = 1'b1;   n_bk = BW'(1);   n_db = SQ_W'(1);
                    n_bany = 1'b0;
                    n_state = (r_skip[1] || (r_cb == '0)) ? S_BDIR : S_RD;
                end else begin
                    n_state = S_GROWEND;
                end
            end
            S_GROWEND: begin
                n_gany = r_gany | r_browany;
                stop = !r_browany && r_gany;
                if (r_gdir) begin
                    cont = ((GW+1)'(r_gk) + 1'b1) <= (GW+1)'(r_cg);
                end else begin
                    cont = ((GW+1)'(r_cg) + (GW+1)'(r_gk) + 1'b1) < GREEN_CELLS;
                end
                n_gk = r_gk + 1'b1;
                n_dg = r_dg + SQ_W'({r_gk, 1'b1});
                n_state = (stop || !cont) ? S_GDIR : S_GROW;
            end
            S_GDIR: begin
                if (!r_gany) begin
                    n_skip[2 + int'(r_gdir)] = 1'b1;
                end
                n_growany = r_growany | r_gany;
                if (!r_gdir) begin
                    n_skip[1:0] = 2'b00;
                    n_gdir = 1'b1;   n_gk = GW'(1);   n_dg = SQ_W'(1);
                    n_gany = 1'b0;
                    n_state = (r_skip[3] || (r_cg == '0)) ? S_GDIR : S_GROW;
                end else begin
                    n_state = S_RROWEND;
                end
            end
            S_RROWEND: begin
                n_rany = r_rany | r_growany;
                stop = !r_growany && r_rany;
                if (r_rdir) begin
                    cont = ((RW+1)'(r_rk) + 1'b1) <= (RW+1)'(r_cr);
                end else begin
                    cont = ((RW+1)'(r_cr) + (RW+1)'(r_rk) + 1'b1) < RED_CELLS;
                end
                n_rk = r_rk + 1'b1;
                n_dr = r_dr + SQ_W'({r_rk, 1'b1});
                n_state = S_RROW;
                if (stop || !cont) begin
                    n_total = r_total | r_rany | r_growany;
                    if (!r_rdir && (r_cr != '0)) begin
                        n_rdir = 1'b1;   n_rk = RW'(1);   n_dr = SQ_W'(1);
                        n_rany = 1'b0;
                        n_skip[3:2] = 2'b00;
                    end else begin
                        n_done = 1'b1;
                        n_result.claimed_any = r_total | r_rany | r_growany;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts the store sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_out <= 1'b0;
            r_skip    <= '0;
            o_done    <= 1'b0;
            o_result  <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_out <= n_clr_out;
            r_skip    <= n_skip;
            o_done    <= n_done;
            o_result  <= n_result;
        end
        r_idx <= n_idx;
        r_cr <= n_cr;   r_cg <= n_cg;   r_cb <= n_cb;
        r_rk <= n_rk;   r_gk <= n_gk;   r_bk <= n_bk;
        r_dr <= n_dr;   r_dg <= n_dg;   r_db <= n_db;
        r_rdir <= n_rdir;   r_gdir <= n_gdir;   r_bdir <= n_bdir;
        r_rany <= n_rany;   r_gany <= n_gany;   r_bany <= n_bany;
        r_total <= n_total;   r_growany <= n_growany;   r_browany <= n_browany;
    end

endmodule
